>>> hw/rtl/set_element_store_top_defines.svh
// assertion macros for the set element store
`ifndef SET_ELEMENT_STORE_TOP_DEFINES_SVH
`define SET_ELEMENT_STORE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SES_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SES_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SES_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/ses_pkg.sv
package ses_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CntW     = 5;
  localparam int unsigned ValW     = 32;

  typedef enum logic [1:0] {
    KIND_QUERY  = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_REMOVE = 2'd2
  } ses_kind_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [ValW-1:0] value;
  } ses_req_t;

  typedef struct packed {
    logic            was_present;
    logic [CntW-1:0] count_after;
    logic            refused_full;
  } ses_rsp_t;

  typedef struct packed {
    logic shift;
    logic load;
  } ses_cell_ctrl_t;

endpackage

>>> hw/rtl/ses_cell.sv
module ses_cell (
  input  logic                            clk_i,
  input  ses_pkg::ses_cell_ctrl_t         ctrl_i,
  input  logic                            occ_i,
  input  logic signed [ses_pkg::ValW-1:0] value_i,
  input  logic signed [ses_pkg::ValW-1:0] next_i,
  output logic signed [ses_pkg::ValW-1:0] elem_o,
  output logic                            match_o
);
  import ses_pkg::*;

  logic signed [ValW-1:0] elem_q, elem_d;

  // compare against the broadcast value, only while the slot is in use
  assign match_o = occ_i && (elem_q == value_i);
  assign elem_o  = elem_q;

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.shift) begin
      elem_d = next_i;
    end else if (ctrl_i.load) begin
      elem_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q <= elem_d;
  end

endmodule

>>> hw/rtl/set_element_store_top.sv
// set element store: chain of compare/shift cells holding up to 16 distinct values
// response: registered, valid in the cycle after the request transfer
// throughput: one request per cycle while no response is held back, set by the
//   compare and compaction across all cells and the response register
// reset: count and response valid clear at once; cell contents stay unknown
`include "set_element_store_top_defines.svh"

module set_element_store_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  ses_pkg::ses_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output ses_pkg::ses_rsp_t rsp_o
);
  import ses_pkg::*;

  // entry count, entries 0 .. count-1 are live
  logic [CntW-1:0] count_q, count_d;

  // response register
  logic     rsp_valid_q, rsp_valid_d;
  ses_rsp_t rsp_q, rsp_d;

  // per cell wiring
  logic [CAPACITY-1:0]    match;
  logic [CAPACITY-1:0]    occ;
  logic [CAPACITY-1:0]    at_or_after;
  logic signed [ValW-1:0] elem [CAPACITY];
  ses_cell_ctrl_t         ctrl [CAPACITY];

  logic accept;
  logic present;
  logic full;
  logic is_add;
  logic is_rem;
  logic do_add;
  logic do_rem;
  logic refused;

  // a new request can enter whenever the response slot is free or draining
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign accept      = req_valid_i && req_ready_o;

  assign present = |match;
  assign full    = (count_q == CntW'(CAPACITY));
  assign is_add  = accept && (req_i.kind == KIND_ADD);
  assign is_rem  = accept && (req_i.kind == KIND_REMOVE);
  assign do_add  = is_add && !present && !full;
  assign do_rem  = is_rem && present;
  assign refused = is_add && !present && full;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    // cell i is live when it sits below the count
    assign occ[i] = (CntW'(i) < count_q);

    // a match at or below cell i means cell i takes its upper neighbor
    assign at_or_after[i] = |(match & ({CAPACITY{1'b1}} >> (CAPACITY - 1 - i)));

    assign ctrl[i].shift = do_rem && at_or_after[i];
    // append lands in the first free cell
    assign ctrl[i].load  = do_add && (count_q == CntW'(i));

    if (i == CAPACITY - 1) begin : g_last
      ses_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl[i]),
        .occ_i   (occ[i]),
        .value_i (req_i.value),
        .next_i  ('0),
        .elem_o  (elem[i]),
        .match_o (match[i])
      );
    end else begin : g_mid
      ses_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl[i]),
        .occ_i   (occ[i]),
        .value_i (req_i.value),
        .next_i  (elem[i+1]),
        .elem_o  (elem[i]),
        .match_o (match[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_add) begin
      count_d = count_q + CntW'(1);
    end else if (do_rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    rsp_d       = rsp_q;
    if (accept) begin
      rsp_valid_d        = 1'b1;
      rsp_d.was_present  = present;
      rsp_d.count_after  = count_d;
      rsp_d.refused_full = refused;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // response payload needs no reset
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // stored values are distinct, so at most one live cell can hit
  `SES_ASSERT_IMPL(a_single_match, clk_i, rst_ni, 1'b1, $onehot0(match))
  `SES_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(CAPACITY))
  `SES_ASSERT_IMPL(a_refuse_only_full, clk_i, rst_ni, refused, full && !present)
  `SES_ASSERT_NEXT(a_add_grows, clk_i, rst_ni, do_add,
                   count_q == $past(count_q) + CntW'(1))
  `SES_ASSERT_NEXT(a_rsp_count, clk_i, rst_ni, accept,
                   rsp_valid_q && (rsp_q.count_after == count_q))

endmodule
